// ===== rtl/ots_pkg.sv =====
// Shared types and constants for the Opus packet timestamp sanitizer.
// Holds the verdict codes, the classified item record and the frame duration function.
// No dependencies.
`default_nettype none

package ots_pkg;

    typedef enum logic [2:0] {
        VERDICT_FORWARD   = 3'd0,
        VERDICT_EMPTY     = 3'd1,
        VERDICT_MALFORMED = 3'd2,
        VERDICT_OTHER     = 3'd3,
        VERDICT_ORDER     = 3'd4,
        VERDICT_MISMATCH  = 3'd5,
        VERDICT_CLOSED    = 3'd6
    } verdict_t;

    // Result of the front classification, travels through the queue
    typedef struct packed {
        logic        clean_end;
        verdict_t    verdict;
        logic [31:0] duration;
    } cls_t;

    localparam logic [11:0] FS_SHORT   = 12'd120;
    localparam logic [11:0] FS_HALF    = 12'd480;
    localparam logic [11:0] FS_FULL    = 12'd960;
    localparam logic [4:0]  CFG_HYBRID = 5'd12;
    localparam logic [4:0]  CFG_CELT   = 5'd16;
    localparam logic [7:0]  COUNT_MASK = 8'h3F;

    localparam logic [1:0]  CODE_SINGLE    = 2'd0;
    localparam logic [1:0]  CODE_ARBITRARY = 2'd3;

    localparam int unsigned DUR_CALC_W = 18;

    // Samples per packet from the TOC byte and the frame count byte
    function automatic logic [DUR_CALC_W-1:0] frame_duration(input logic [7:0] toc,
                                                             input logic [7:0] cnt);
        logic [4:0]  mode;
        logic [11:0] fs;
        logic [5:0]  n;
        mode = toc[7:3];
        if (mode < CFG_HYBRID) begin
            fs = (mode[1:0] == 2'd0) ? FS_HALF : 12'(FS_FULL * mode[1:0]);
        end else if (mode < CFG_CELT) begin
            fs = 12'(FS_HALF << mode[0]);
        end else begin
            fs = 12'(FS_SHORT << mode[1:0]);
        end
        case (toc[1:0])
            CODE_SINGLE:    n = 6'd1;
            CODE_ARBITRARY: n = 6'(cnt & COUNT_MASK);
            default:        n = 6'd2;
        endcase
        frame_duration = {6'd0, fs} * {12'd0, n};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ots_front.sv =====
// Front stage: takes input words, resolves the stateless verdicts and the duration.
// Holds the target stream register. Depends on ots_pkg.
`default_nettype none

module ots_front
    import ots_pkg::*;
#(
    parameter int TS_WIDTH = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic [3:0]          cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [199:0]        s_tdata,
    input  wire logic [0:0]          s_tuser,
    input  wire logic                s_tlast,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cls_t                     out_cls,
    output logic [TS_WIDTH-1:0]      out_pts,
    output logic [TS_WIDTH-1:0]      out_dts
);

    logic [3:0]          target_reg;
    logic                valid_reg;
    cls_t                cls_reg;
    logic [TS_WIDTH-1:0] pts_reg;
    logic [TS_WIDTH-1:0] dts_reg;

    logic [3:0]  pkt_stream;
    logic [15:0] pkt_size;
    logic        has_data;
    logic [31:0] given_dur;
    logic [7:0]  toc;
    logic [7:0]  cnt;
    logic        malformed;
    cls_t        cls_next;
    logic        load;

    assign pkt_stream = s_tdata[3:0];
    assign pkt_size   = s_tdata[19:4];
    assign has_data   = s_tdata[20];
    assign given_dur  = s_tdata[52:21];
    assign toc        = s_tdata[60:53];
    assign cnt        = s_tdata[68:61];

    assign s_tready = !valid_reg || out_ready;
    assign load     = s_tvalid && s_tready;

    assign malformed = (given_dur == 32'd0) && has_data && (toc[1:0] == CODE_ARBITRARY)
                       && (pkt_size < 16'd2);

    always_comb begin
        cls_next.clean_end = s_tuser[0];
        cls_next.duration  = given_dur;
        if (given_dur == 32'd0 && has_data) begin
            cls_next.duration = 32'(frame_duration(toc, cnt));
        end
        if (s_tlast) begin
            cls_next.verdict = VERDICT_CLOSED;
        end else if (pkt_size == 16'd0) begin
            cls_next.verdict = VERDICT_EMPTY;
        end else if (malformed) begin
            cls_next.verdict = VERDICT_MALFORMED;
        end else if (pkt_stream != target_reg) begin
            cls_next.verdict = VERDICT_OTHER;
        end else begin
            cls_next.verdict = VERDICT_FORWARD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 4'd0;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                target_reg <= cfg_data;
            end
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cls_reg <= cls_next;
            pts_reg <= s_tdata[69 +: TS_WIDTH];
            dts_reg <= s_tdata[133 +: TS_WIDTH];
        end
    end

    assign out_valid = valid_reg;
    assign out_cls   = cls_reg;
    assign out_pts   = pts_reg;
    assign out_dts   = dts_reg;

endmodule

`default_nettype wire

// ===== rtl/ots_queue.sv =====
// Two-entry queue between the front and the back stage.
// Generic width, no package dependency.
`default_nettype none

module ots_queue #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    localparam int DEPTH = 2;

    logic [W-1:0] mem [DEPTH];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop;

    assign in_ready  = (count_reg != 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ots_back.sv =====
// Back stages: order and pts/dts checks with the start correction, then offset
// addition, expected-next tracking and the output register. Depends on ots_pkg.
`default_nettype none

module ots_back
    import ots_pkg::*;
#(
    parameter int TS_WIDTH = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cls_t                in_cls,
    input  wire logic [TS_WIDTH-1:0] in_pts,
    input  wire logic [TS_WIDTH-1:0] in_dts,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [223:0]             m_tdata,
    output logic [2:0]               m_tuser
);

    // first stage state
    logic [TS_WIDTH-1:0] last_pts_reg, last_pts_next;
    logic                last_valid_reg, last_valid_next;
    logic [TS_WIDTH-1:0] corr_reg, corr_next;
    logic                corr_valid_reg, corr_valid_next;

    // first stage word
    logic                b1_valid_reg;
    verdict_t            b1_verdict_reg, b1_verdict_next;
    logic                b1_clean_reg;
    logic [31:0]         b1_dur_reg;
    logic [TS_WIDTH-1:0] b1_pc_reg, b1_pc_next;

    // second stage state
    logic [TS_WIDTH-1:0] offset_reg, offset_next;
    logic [TS_WIDTH-1:0] last_opts_reg, last_opts_next;
    logic [31:0]         last_dur_reg, last_dur_next;
    logic                exp_valid_reg, exp_valid_next;

    // output word
    logic                m_valid_reg;
    verdict_t            m_verdict_reg;
    logic [TS_WIDTH-1:0] m_pts_reg, m_pts_next;
    logic [31:0]         m_dur_reg, m_dur_next;
    logic [TS_WIDTH-1:0] m_offset_reg;

    logic                b1_ready;
    logic                b1_load;
    logic                b2_ready;
    logic                b2_load;
    logic                pts_less;
    logic [TS_WIDTH-1:0] pts_corr_sum;
    logic [TS_WIDTH-1:0] neg_pts;
    logic [TS_WIDTH-1:0] opts_sum;
    logic [TS_WIDTH-1:0] commit_sum;

    assign b2_ready = !m_valid_reg || m_tready;
    assign b1_ready = !b1_valid_reg || b2_ready;
    assign b1_load  = in_valid && b1_ready;
    assign b2_load  = b1_valid_reg && b2_ready;
    assign in_ready = b1_ready;

    assign pts_less     = $signed(in_pts) < $signed(last_pts_reg);
    assign pts_corr_sum = in_pts + corr_reg;
    assign neg_pts      = {TS_WIDTH{1'b0}} - in_pts;

    // order check, mismatch check, start correction
    always_comb begin
        last_pts_next   = last_pts_reg;
        last_valid_next = last_valid_reg;
        corr_next       = corr_reg;
        corr_valid_next = corr_valid_reg;
        b1_verdict_next = in_cls.verdict;
        b1_pc_next      = {TS_WIDTH{1'b0}};
        if (in_cls.verdict == VERDICT_CLOSED) begin
            last_pts_next   = {TS_WIDTH{1'b0}};
            last_valid_next = 1'b0;
            corr_next       = {TS_WIDTH{1'b0}};
            corr_valid_next = 1'b0;
        end else if (in_cls.verdict == VERDICT_FORWARD) begin
            if (last_valid_reg && pts_less) begin
                b1_verdict_next = VERDICT_ORDER;
            end else begin
                last_pts_next   = in_pts;
                last_valid_next = 1'b1;
                if (in_pts != in_dts) begin
                    b1_verdict_next = VERDICT_MISMATCH;
                end else if (!corr_valid_reg) begin
                    // lift a negative start to zero
                    corr_valid_next = 1'b1;
                    corr_next  = in_pts[TS_WIDTH-1] ? neg_pts : {TS_WIDTH{1'b0}};
                    b1_pc_next = in_pts[TS_WIDTH-1] ? {TS_WIDTH{1'b0}} : in_pts;
                end else begin
                    b1_pc_next = pts_corr_sum;
                end
            end
        end
    end

    assign opts_sum   = b1_pc_reg + offset_reg;
    assign commit_sum = last_opts_reg + TS_WIDTH'(last_dur_reg);

    // offset addition and expected-next tracking
    always_comb begin
        offset_next    = offset_reg;
        last_opts_next = last_opts_reg;
        last_dur_next  = last_dur_reg;
        exp_valid_next = exp_valid_reg;
        m_pts_next     = {TS_WIDTH{1'b0}};
        m_dur_next     = 32'd0;
        if (b1_verdict_reg == VERDICT_CLOSED) begin
            if (b1_clean_reg && exp_valid_reg) begin
                offset_next = commit_sum;
            end
            exp_valid_next = 1'b0;
        end else if (b1_verdict_reg == VERDICT_FORWARD) begin
            m_pts_next     = opts_sum;
            m_dur_next     = b1_dur_reg;
            last_opts_next = opts_sum;
            last_dur_next  = b1_dur_reg;
            exp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pts_reg   <= {TS_WIDTH{1'b0}};
            last_valid_reg <= 1'b0;
            corr_reg       <= {TS_WIDTH{1'b0}};
            corr_valid_reg <= 1'b0;
            b1_valid_reg   <= 1'b0;
            offset_reg     <= {TS_WIDTH{1'b0}};
            last_opts_reg  <= {TS_WIDTH{1'b0}};
            last_dur_reg   <= 32'd0;
            exp_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (b1_load) begin
                last_pts_reg   <= last_pts_next;
                last_valid_reg <= last_valid_next;
                corr_reg       <= corr_next;
                corr_valid_reg <= corr_valid_next;
                b1_valid_reg   <= 1'b1;
            end else if (b2_load) begin
                b1_valid_reg <= 1'b0;
            end
            if (b2_load) begin
                offset_reg    <= offset_next;
                last_opts_reg <= last_opts_next;
                last_dur_reg  <= last_dur_next;
                exp_valid_reg <= exp_valid_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b1_load) begin
            b1_verdict_reg <= b1_verdict_next;
            b1_clean_reg   <= in_cls.clean_end;
            b1_dur_reg     <= in_cls.duration;
            b1_pc_reg      <= b1_pc_next;
        end
        if (b2_load) begin
            m_verdict_reg <= b1_verdict_reg;
            m_pts_reg     <= m_pts_next;
            m_dur_reg     <= m_dur_next;
            m_offset_reg  <= offset_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_verdict_reg;
    assign m_tdata  = {64'($signed(m_offset_reg)), m_dur_reg,
                       64'($signed(m_pts_reg)), 64'($signed(m_pts_reg))};

endmodule

`default_nettype wire

// ===== rtl/opus_packet_timestamp_sanitizer.sv =====
// Path: front register, two-entry queue, first back stage, then the output register.
// Throughput: one word per cycle while m_tready stays high; a stall on m_tready holds
// the flow back through the stages and the queue to s_tready.
// Reset: aresetn is synchronous, active low; it empties the queue and all stages,
// clears the offset, the correction and the order state, and sets target_stream to 0.
// Top level: front classifier, two-entry queue and back stages. Depends on ots_pkg.
`default_nettype none

module opus_packet_timestamp_sanitizer
    import ots_pkg::*;
#(
    parameter int TS_WIDTH = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [3:0]   cfg_data,     // target_stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // packet_stream, packet_size, has_data, given_duration, toc_byte, count_byte,
    // in_pts, in_dts, zero fill
    input  wire logic [199:0] s_tdata,
    input  wire logic [0:0]   s_tuser,      // clean_end
    input  wire logic         s_tlast,      // kind: segment end
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_pts, out_dts, out_duration, offset_now
    output logic [223:0]      m_tdata,
    output logic [2:0]        m_tuser       // verdict
);

    localparam int QW = $bits(cls_t) + 2 * TS_WIDTH;

    logic                f_valid;
    logic                f_ready;
    cls_t                f_cls;
    logic [TS_WIDTH-1:0] f_pts;
    logic [TS_WIDTH-1:0] f_dts;
    logic                q_valid;
    logic                q_ready;
    logic [QW-1:0]       q_data;
    cls_t                q_cls;
    logic [TS_WIDTH-1:0] q_pts;
    logic [TS_WIDTH-1:0] q_dts;

    assign cfg_ready = 1'b1;

    ots_front #(
        .TS_WIDTH (TS_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_cls   (f_cls),
        .out_pts   (f_pts),
        .out_dts   (f_dts)
    );

    ots_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_cls, f_pts, f_dts}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_dts = q_data[TS_WIDTH-1:0];
    assign q_pts = q_data[2*TS_WIDTH-1:TS_WIDTH];
    assign q_cls = q_data[QW-1:2*TS_WIDTH];

    ots_back #(
        .TS_WIDTH (TS_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_cls   (q_cls),
        .in_pts   (q_pts),
        .in_dts   (q_dts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/ots_checker.sv =====
// Port-level checks for the timestamp sanitizer, bound to the top level.
// Depends on ots_pkg.
`default_nettype none

module ots_checker
    import ots_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [3:0]   cfg_data,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [199:0] s_tdata,
    input wire logic [0:0]   s_tuser,
    input wire logic         s_tlast,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [223:0] m_tdata,
    input wire logic [2:0]   m_tuser
);

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != VERDICT_FORWARD |-> m_tdata[159:0] == 160'd0)
        else $error("dropped word carries timestamps or duration");

    a_pts_dts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == VERDICT_FORWARD |-> m_tdata[63:0] == m_tdata[127:64])
        else $error("forwarded word with differing pts and dts");

    a_no_output_without_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result word appeared straight out of reset");

endmodule

bind opus_packet_timestamp_sanitizer ots_checker u_ots_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the Opus packet timestamp sanitizer: directed drops, duration
// decoding, segment ends and random packet traffic under changing back-pressure.
// Depends on ots_pkg and the top level opus_packet_timestamp_sanitizer.
`default_nettype none

module tb_top;
    import ots_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SAMPLES_SHORT  = 120;
    localparam int unsigned SAMPLES_HALF   = 480;
    localparam int unsigned SAMPLES_FULL   = 960;
    localparam logic [4:0]  MODE_HYBRID    = 5'd12;
    localparam logic [4:0]  MODE_CELT      = 5'd16;
    localparam logic [1:0]  CODE_ONE_FRAME = 2'd0;
    localparam logic [1:0]  CODE_COUNTED   = 2'd3;
    localparam logic [7:0]  FRAME_CNT_MASK = 8'h3F;
    localparam logic [63:0] TS_MIN         = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TS_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic        clean;
        logic [3:0]  stream;
        logic [15:0] size;
        logic        has_data;
        logic [31:0] dur;
        logic [7:0]  toc;
        logic [7:0]  cnt;
        logic [63:0] pts;
        logic [63:0] dts;
    } packet_desc_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [63:0] pts;
        logic [63:0] dts;
        logic [31:0] dur;
        logic [63:0] offset;
    } retimed_t;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [3:0]     cfg_data  = '0;
    logic           s_tvalid  = 1'b0;
    logic           s_tready;
    logic [199:0]   s_tdata   = '0;
    logic [0:0]     s_tuser   = '0;
    logic           s_tlast   = 1'b0;
    logic           m_tvalid;
    logic           m_tready  = 1'b0;
    logic [223:0]   m_tdata;
    logic [2:0]     m_tuser;

    // Model state of the sanitizer
    logic [3:0]  tgt_stream;
    logic [63:0] offset_q;
    logic [63:0] seen_pts;
    logic        seen_pts_ok;
    logic [63:0] corr;
    logic        corr_ok;
    logic [63:0] next_pts;
    logic        next_pts_ok;

    retimed_t    pending_outcomes[$];
    int          errors        = 0;
    int          words_sent    = 0;
    int          results_seen  = 0;
    int          verdict_hist[7];
    int          src_gap_pct   = 0;
    int          snk_gap_pct   = 0;
    logic [63:0] pts_cursor    = '0;

    opus_packet_timestamp_sanitizer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // stream, size, has_data, duration, toc, count, pts, dts
        .s_tuser   (s_tuser),   // clean_end
        .s_tlast   (s_tlast),   // segment end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_pts, out_dts, out_duration, offset_now
        .m_tuser   (m_tuser)    // verdict
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_gap_pct);
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        retimed_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result word with no outcome pending");
                errors++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("verdict", 64'(want.verdict), 64'(m_tuser));
                check_field("out_pts", want.pts, m_tdata[63:0]);
                check_field("out_dts", want.dts, m_tdata[127:64]);
                check_field("out_duration", 64'(want.dur), 64'(m_tdata[159:128]));
                check_field("offset_now", want.offset, m_tdata[223:160]);
                results_seen++;
                verdict_hist[want.verdict]++;
            end
        end
    end

    task automatic classify_and_retime(input packet_desc_t it, output retimed_t r);
        logic [4:0]  mode;
        logic [31:0] fs;
        logic [31:0] frames;
        logic [31:0] dur;
        logic        malformed;
        r = '0;
        r.verdict = VERDICT_FORWARD;
        dur = it.dur;
        malformed = 1'b0;
        // derive the duration from the TOC only when the demuxer gave none
        if (dur == 0 && it.has_data) begin
            mode = it.toc[7:3];
            if (mode < MODE_HYBRID)
                fs = (mode[1:0] == 2'd0) ? SAMPLES_HALF : SAMPLES_FULL * mode[1:0];
            else if (mode < MODE_CELT)
                fs = SAMPLES_HALF << mode[0];
            else
                fs = SAMPLES_SHORT << mode[1:0];
            if (it.toc[1:0] == CODE_COUNTED) begin
                frames = 32'(it.cnt & FRAME_CNT_MASK);
                malformed = (it.size < 2);
            end else begin
                frames = (it.toc[1:0] == CODE_ONE_FRAME) ? 32'd1 : 32'd2;
            end
            if (!malformed)
                dur = fs * frames;
        end
        if (it.kind) begin
            if (it.clean && next_pts_ok)
                offset_q = next_pts;
            seen_pts    = '0;
            seen_pts_ok = 1'b0;
            corr        = '0;
            corr_ok     = 1'b0;
            next_pts    = '0;
            next_pts_ok = 1'b0;
            r.verdict   = VERDICT_CLOSED;
        end else if (it.size == 0) begin
            r.verdict = VERDICT_EMPTY;
        end else if (malformed) begin
            r.verdict = VERDICT_MALFORMED;
        end else if (it.stream != tgt_stream) begin
            r.verdict = VERDICT_OTHER;
        end else if (seen_pts_ok && ($signed(it.pts) < $signed(seen_pts))) begin
            r.verdict = VERDICT_ORDER;
        end else begin
            seen_pts    = it.pts;
            seen_pts_ok = 1'b1;
            if (it.pts != it.dts) begin
                r.verdict = VERDICT_MISMATCH;
            end else begin
                if (!corr_ok) begin
                    corr    = it.pts[63] ? -it.pts : 64'd0;
                    corr_ok = 1'b1;
                end
                r.pts       = it.pts + corr + offset_q;
                r.dts       = it.dts + corr + offset_q;
                r.dur       = dur;
                next_pts    = r.pts + {32'd0, dur};
                next_pts_ok = 1'b1;
            end
        end
        r.offset = offset_q;
    endtask

    task automatic send_word(input packet_desc_t it);
        retimed_t r;
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tlast  <= it.kind;
        s_tuser  <= it.clean;
        s_tdata  <= {3'b0, it.dts, it.pts, it.cnt, it.toc, it.dur, it.has_data,
                     it.size, it.stream};
        do @(posedge aclk); while (!s_tready);
        classify_and_retime(it, r);
        pending_outcomes.push_back(r);
        words_sent++;
    endtask

    // Hold the input until every outcome has been checked
    task automatic drain_outcomes();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_target(input logic [3:0] value);
        drain_outcomes();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tgt_stream = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic packet_desc_t packet(input logic [3:0] stream, input logic [15:0] size,
                                            input logic has_data, input logic [31:0] dur,
                                            input logic [7:0] toc, input logic [7:0] cnt,
                                            input logic [63:0] pts, input logic [63:0] dts);
        packet_desc_t it;
        it = '{kind: 1'b0, clean: 1'b0, stream: stream, size: size, has_data: has_data,
               dur: dur, toc: toc, cnt: cnt, pts: pts, dts: dts};
        return it;
    endfunction

    function automatic packet_desc_t segment_end(input logic clean);
        packet_desc_t it;
        it = '0;
        it.kind  = 1'b1;
        it.clean = clean;
        return it;
    endfunction

    task automatic test_drop_reasons();
        send_word(packet(4'd0, 16'd0, 1'b1, 32'd960, 8'h00, 8'h00, 64'd10, 64'd10));
        send_word(packet(4'd0, 16'd1, 1'b1, 32'd0, 8'h03, 8'h05, 64'd10, 64'd10));
        // malformed wins over the stream test
        send_word(packet(4'd9, 16'd1, 1'b1, 32'd0, 8'hFB, 8'h02, 64'd10, 64'd10));
        send_word(packet(4'd15, 16'd80, 1'b1, 32'd960, 8'h00, 8'h00, 64'd10, 64'd10));
        send_word(packet(4'd0, 16'd80, 1'b1, 32'd960, 8'h00, 8'h00, 64'd1000, 64'd1000));
        send_word(packet(4'd0, 16'd80, 1'b1, 32'd960, 8'h00, 8'h00, 64'd999, 64'd999));
        // a mismatch still moves last pts on, so 1500 then falls out of order
        send_word(packet(4'd0, 16'd80, 1'b1, 32'd960, 8'h00, 8'h00, 64'd2000, 64'd2001));
        send_word(packet(4'd0, 16'd80, 1'b1, 32'd960, 8'h00, 8'h00, 64'd1500, 64'd1500));
    endtask

    task automatic test_duration_rules();
        send_word(packet(4'd0, 16'd40, 1'b0, 32'd0, 8'hFF, 8'hFF, 64'd3000, 64'd3000));
        send_word(packet(4'd0, 16'd2, 1'b1, 32'd0, 8'h03, 8'hC0, 64'd3100, 64'd3100));
        send_word(packet(4'd0, 16'hFFFF, 1'b1, 32'd0, 8'hFF, 8'hFF, 64'd3200, 64'd3200));
        send_word(packet(4'd0, 16'd60, 1'b1, 32'd0, {5'd13, 3'd1}, 8'h00, 64'd3300, 64'd3300));
        send_word(packet(4'd0, 16'd60, 1'b1, 32'd0, {5'd3, 3'd2}, 8'h00, 64'd3400, 64'd3400));
        send_word(packet(4'd0, 16'd60, 1'b1, 32'hFFFF_FFFF, 8'h00, 8'h00,
                         64'd3500, 64'd3500));
    endtask

    task automatic test_segment_ends();
        send_word(segment_end(1'b1));
        // negating the most negative pts leaves it unchanged
        send_word(packet(4'd0, 16'd10, 1'b1, 32'd120, 8'h80, 8'h00, TS_MIN, TS_MIN));
        send_word(packet(4'd0, 16'd10, 1'b1, 32'd120, 8'h80, 8'h00, TS_MAX, TS_MAX));
        send_word(segment_end(1'b0));
        send_word(segment_end(1'b1));
        send_word(packet(4'd0, 16'd10, 1'b1, 32'd0, 8'h08, 8'h00, -64'sd500, -64'sd500));
        send_word(segment_end(1'b1));
    endtask

    task automatic random_packet(output packet_desc_t it);
        int pick;
        pick = $urandom_range(99);
        it.kind     = 1'b0;
        it.clean    = 1'($urandom_range(1));
        it.stream   = tgt_stream;
        it.size     = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1500));
        it.has_data = ($urandom_range(9) != 0);
        it.dur      = ($urandom_range(3) == 0) ? $urandom : 32'd0;
        it.toc      = 8'($urandom);
        it.cnt      = 8'($urandom);
        it.pts      = pts_cursor;
        it.dts      = pts_cursor;
        if (pick < 6) begin
            it.kind  = 1'b1;
            it.clean = ($urandom_range(3) != 0);
            if ($urandom_range(4) == 0)
                pts_cursor = {$urandom, $urandom};
            else
                pts_cursor = 64'($signed($urandom_range(200000)) - 100000);
        end else if (pick < 10) begin
            it.stream = 4'($urandom);
        end else if (pick < 13) begin
            it.size = '0;
        end else if (pick < 17) begin
            it.pts = pts_cursor - 64'($urandom_range(1, 5000));
            it.dts = it.pts;
        end else if (pick < 21) begin
            it.dts = pts_cursor + 64'($urandom_range(1, 5000));
        end else if (pick < 25) begin
            it.size     = 16'($urandom);
            it.stream   = 4'($urandom);
            it.pts      = {$urandom, $urandom};
            it.dts      = ($urandom_range(1) == 0) ? it.pts : {$urandom, $urandom};
        end else begin
            pts_cursor = pts_cursor + 64'($urandom_range(0, 5760));
        end
    endtask

    task automatic test_random_traffic(input int count, input logic [3:0] target,
                                       input int src_pct, input int snk_pct);
        packet_desc_t it;
        write_target(target);
        src_gap_pct = src_pct;
        snk_gap_pct = snk_pct;
        pts_cursor  = 64'($urandom_range(100000));
        send_word(segment_end(1'b1));
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                drain_outcomes();
            random_packet(it);
            send_word(it);
        end
    endtask

    initial begin
        int waited;
        tgt_stream  = '0;
        offset_q    = '0;
        seen_pts    = '0;
        seen_pts_ok = 1'b0;
        corr        = '0;
        corr_ok     = 1'b0;
        next_pts    = '0;
        next_pts_ok = 1'b0;
        foreach (verdict_hist[v]) verdict_hist[v] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_gap_pct = 18;
        snk_gap_pct = 46;
        test_drop_reasons();
        test_duration_rules();
        test_segment_ends();
        test_random_traffic(165, 4'd15, 18, 46);
        test_random_traffic(165, 4'($urandom_range(1, 14)), 46, 18);
        test_random_traffic(165, 4'd0, 0, 0);

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d outcomes never arrived", pending_outcomes.size());
            errors++;
        end

        $display("Sent %0d words over four target stream settings, checked %0d results",
                 words_sent, results_seen);
        $display("Verdicts: fwd %0d empty %0d malformed %0d other %0d",
                 verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3],
                 " order %0d mismatch %0d closed %0d",
                 verdict_hist[4], verdict_hist[5], verdict_hist[6]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
